FILE: hdl/tcse_pkg.sv
// Shared constants, types and helper functions for the terminal control sequence encoder.
`default_nettype none

package tcse_pkg;

  // Field widths of the command and byte channels.
  localparam int CMD_COORD_W    = 16;
  localparam int RGB_W          = 24;
  localparam int CHAN_W         = 8;
  localparam int BYTE_W         = 8;

  // Default coordinate width and structural constants.
  localparam int COORD_BITS_DEF = 16;
  localparam int LANES          = 3;
  localparam int COLOUR_DIGITS  = 3;
  localparam int QUEUE_DEPTH    = 2;
  localparam int SEQ_MAX        = 19;
  localparam int HDR_W          = 3;
  localparam logic [HDR_W-1:0] HDR_LAST = 3'd4;

  // Command opcodes.
  localparam logic OP_CURSOR = 1'b0;
  localparam logic OP_COLOUR = 1'b1;

  // ASCII characters used in the sequences.
  localparam logic [BYTE_W-1:0] CH_ESC    = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_H      = 8'h48;
  localparam logic [BYTE_W-1:0] CH_M      = 8'h6D;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_TWO    = 8'h32;
  localparam logic [BYTE_W-1:0] CH_THREE  = 8'h33;
  localparam logic [BYTE_W-1:0] CH_FOUR   = 8'h34;
  localparam logic [BYTE_W-1:0] CH_EIGHT  = 8'h38;

  // Per-command control bits carried from the front end to the back end.
  typedef struct packed {
    logic opcode;
    logic foreground;
  } cmd_ctrl_t;

  // Front end: load, binary to BCD conversion, hand-off to the queue.
  typedef enum logic [1:0] {
    FS_IDLE,
    FS_CONV,
    FS_PUSH
  } front_state_t;

  // Back end: one state per kind of byte in the sequence.
  typedef enum logic [2:0] {
    BS_ESC,
    BS_BRACKET,
    BS_HDR,
    BS_DIGIT,
    BS_SEP,
    BS_END
  } back_state_t;

  // Double-dabble correction for one BCD digit.
  function automatic logic [3:0] bcd_adj(input logic [3:0] d);
    logic [3:0] r;
    r = (d >= 4'd5) ? (d + 4'd3) : d;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/tcse_cmd_if.sv
// Command channel interface: valid, ready and one command beat.
`default_nettype none

interface tcse_cmd_if;
  logic                            valid;
  logic                            ready;
  logic                            opcode;
  logic [tcse_pkg::CMD_COORD_W-1:0] row;
  logic [tcse_pkg::CMD_COORD_W-1:0] column;
  logic [tcse_pkg::RGB_W-1:0]       rgb;
  logic                            foreground;

  modport source (output valid, opcode, row, column, rgb, foreground, input ready);
  modport sink   (input valid, opcode, row, column, rgb, foreground, output ready);
endinterface

`default_nettype wire

FILE: hdl/tcse_byte_if.sv
// Byte channel interface: valid, ready, one sequence byte and its last flag.
`default_nettype none

interface tcse_byte_if;
  logic                        valid;
  logic                        ready;
  logic [tcse_pkg::BYTE_W-1:0] out_byte;
  logic                        last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

`default_nettype wire

FILE: hdl/tcse_front.sv
// Front end: accepts commands and converts coordinates or colour channels to BCD digits.
`default_nettype none

module tcse_front #(
  parameter int COORD_BITS = tcse_pkg::COORD_BITS_DEF,
  parameter int CONV_W     = tcse_pkg::CMD_COORD_W,
  parameter int NDIG       = 5,
  parameter int CNT_W      = 3
) (
  input  logic                                clk,
  input  logic                                rst,
  tcse_cmd_if.sink                            cmd,
  output logic                                job_valid,
  input  logic                                job_ready,
  output tcse_pkg::cmd_ctrl_t                 job_ctrl,
  output logic [tcse_pkg::LANES*NDIG*4-1:0]   job_digits,
  output logic [CNT_W-1:0]                    job_cnt0,
  output logic [CNT_W-1:0]                    job_cnt1
);
  import tcse_pkg::*;

  localparam int CW     = (COORD_BITS < CMD_COORD_W) ? COORD_BITS : CMD_COORD_W;
  localparam int ITER_W = $clog2(CONV_W + 1);
  localparam int BCD_W  = NDIG * 4;

  front_state_t             state, state_next;
  logic [CONV_W-1:0]        bin [LANES];
  logic [BCD_W-1:0]         bcd [LANES];
  logic [BCD_W-1:0]         bcd_next [LANES];
  logic [ITER_W-1:0]        iter;
  cmd_ctrl_t                ctrl;
  logic                     accept;
  logic                     conv_done;
  logic [CNT_W-1:0]         sig_cnt [2];

  assign accept    = cmd.valid && cmd.ready;
  assign conv_done = (iter == ITER_W'(CONV_W - 1));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      FS_IDLE: if (accept) state_next = FS_CONV;
      FS_CONV: if (conv_done) state_next = FS_PUSH;
      FS_PUSH: begin
        if (job_ready) state_next = accept ? FS_CONV : FS_IDLE;
      end
      default: state_next = FS_IDLE;
    endcase
  end

  // Handshake outputs; a new command is taken in the cycle the finished one leaves.
  always_comb begin
    cmd.ready = 1'b0;
    job_valid = 1'b0;
    case (state)
      FS_IDLE: cmd.ready = 1'b1;
      FS_PUSH: begin
        job_valid = 1'b1;
        cmd.ready = job_ready;
      end
      default: begin
        cmd.ready = 1'b0;
        job_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // One double-dabble step per lane: correct every digit, then shift in the next bit.
  always_comb begin
    logic [BCD_W-1:0] adj;
    for (int l = 0; l < LANES; l++) begin
      adj = '0;
      for (int d = 0; d < NDIG; d++) begin
        adj[d*4 +: 4] = bcd_adj(bcd[l][d*4 +: 4]);
      end
      bcd_next[l] = {adj[BCD_W-2:0], bin[l][CONV_W-1]};
    end
  end

  // Conversion datapath: load on accept, then one bit per cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      ctrl.opcode     <= cmd.opcode;
      ctrl.foreground <= cmd.foreground;
      iter            <= '0;
      for (int l = 0; l < LANES; l++) begin
        bcd[l] <= '0;
      end
      if (cmd.opcode == OP_COLOUR) begin
        bin[0] <= CONV_W'(cmd.rgb[3*CHAN_W-1:2*CHAN_W]);
        bin[1] <= CONV_W'(cmd.rgb[2*CHAN_W-1:CHAN_W]);
        bin[2] <= CONV_W'(cmd.rgb[CHAN_W-1:0]);
      end else begin
        bin[0] <= CONV_W'(cmd.row[CW-1:0]);
        bin[1] <= CONV_W'(cmd.column[CW-1:0]);
        bin[2] <= '0;
      end
    end else if (state == FS_CONV) begin
      iter <= iter + ITER_W'(1);
      for (int l = 0; l < LANES; l++) begin
        bcd[l] <= bcd_next[l];
        bin[l] <= {bin[l][CONV_W-2:0], 1'b0};
      end
    end
  end

  // Count of significant digits of each coordinate; zero gives no digits.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sig_cnt[l] = '0;
      for (int d = 0; d < NDIG; d++) begin
        if (bcd[l][d*4 +: 4] != 4'd0) sig_cnt[l] = CNT_W'(d + 1);
      end
    end
  end

  assign job_ctrl   = ctrl;
  assign job_digits = {bcd[2], bcd[1], bcd[0]};
  assign job_cnt0   = (ctrl.opcode == OP_COLOUR) ? CNT_W'(COLOUR_DIGITS) : sig_cnt[0];
  assign job_cnt1   = (ctrl.opcode == OP_COLOUR) ? CNT_W'(COLOUR_DIGITS) : sig_cnt[1];

endmodule

`default_nettype wire

FILE: hdl/tcse_fifo.sv
// Short queue of converted commands between the front end and the back end.
`default_nettype none

module tcse_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tcse_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= in_data;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tcse_back.sv
// Back end: walks one converted command and emits its bytes through an output register.
`default_nettype none

module tcse_back #(
  parameter int NDIG  = 5,
  parameter int CNT_W = 3
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              job_valid,
  output logic                              job_ready,
  input  tcse_pkg::cmd_ctrl_t               job_ctrl,
  input  logic [tcse_pkg::LANES*NDIG*4-1:0] job_digits,
  input  logic [CNT_W-1:0]                  job_cnt0,
  input  logic [CNT_W-1:0]                  job_cnt1,
  tcse_byte_if.source                       seq
);
  import tcse_pkg::*;

  localparam int DIG_W = $clog2(NDIG);
  localparam int BCD_W = NDIG * 4;

  back_state_t       state, state_next;
  logic [HDR_W-1:0]  hdr, hdr_next;
  logic [1:0]        lane, lane_next;
  logic [DIG_W-1:0]  dig, dig_next;
  logic              adv;
  logic              colour;
  logic [1:0]        last_lane;
  logic [CNT_W-1:0]  lane_cnt [LANES];
  logic [CNT_W-1:0]  next_cnt;
  logic [BCD_W-1:0]  lane_bcd [LANES];
  logic [3:0]        digit;
  logic [BYTE_W-1:0] byte_cur;
  logic              last_cur;
  logic              ov;
  logic [BYTE_W-1:0] ob;
  logic              ol;

  assign colour    = (job_ctrl.opcode == OP_COLOUR);
  assign last_lane = colour ? 2'd2 : 2'd1;
  assign adv       = job_valid && (!ov || seq.ready);

  // Per-lane digit counts and digit fields of the current command.
  always_comb begin
    lane_cnt[0] = job_cnt0;
    lane_cnt[1] = job_cnt1;
    lane_cnt[2] = CNT_W'(COLOUR_DIGITS);
    for (int l = 0; l < LANES; l++) begin
      lane_bcd[l] = job_digits[l*BCD_W +: BCD_W];
    end
  end

  assign next_cnt = lane_cnt[lane + 2'd1];
  assign digit    = lane_bcd[lane][dig*4 +: 4];

  // Next state and position counters.
  always_comb begin
    state_next = state;
    hdr_next   = hdr;
    lane_next  = lane;
    dig_next   = dig;
    if (adv) begin
      case (state)
        BS_ESC: state_next = BS_BRACKET;
        BS_BRACKET: begin
          lane_next = 2'd0;
          hdr_next  = '0;
          if (colour) begin
            state_next = BS_HDR;
          end else if (job_cnt0 == '0) begin
            state_next = BS_SEP;
          end else begin
            state_next = BS_DIGIT;
            dig_next   = DIG_W'(job_cnt0 - CNT_W'(1));
          end
        end
        BS_HDR: begin
          if (hdr == HDR_LAST) begin
            state_next = BS_DIGIT;
            dig_next   = DIG_W'(COLOUR_DIGITS - 1);
          end else begin
            hdr_next = hdr + HDR_W'(1);
          end
        end
        BS_DIGIT: begin
          if (dig == '0) begin
            state_next = (lane == last_lane) ? BS_END : BS_SEP;
          end else begin
            dig_next = dig - DIG_W'(1);
          end
        end
        BS_SEP: begin
          lane_next = lane + 2'd1;
          if (next_cnt == '0) begin
            state_next = BS_END;
          end else begin
            state_next = BS_DIGIT;
            dig_next   = DIG_W'(next_cnt - CNT_W'(1));
          end
        end
        BS_END: state_next = BS_ESC;
        default: state_next = BS_ESC;
      endcase
    end
  end

  // Byte for the current position.
  always_comb begin
    byte_cur  = CH_SEMI;
    last_cur  = 1'b0;
    job_ready = 1'b0;
    case (state)
      BS_ESC:     byte_cur = CH_ESC;
      BS_BRACKET: byte_cur = CH_LBRACK;
      BS_HDR: begin
        case (hdr)
          3'd0:    byte_cur = job_ctrl.foreground ? CH_THREE : CH_FOUR;
          3'd1:    byte_cur = CH_EIGHT;
          3'd3:    byte_cur = CH_TWO;
          default: byte_cur = CH_SEMI;
        endcase
      end
      BS_DIGIT:   byte_cur = CH_ZERO | {4'd0, digit};
      BS_SEP:     byte_cur = CH_SEMI;
      BS_END: begin
        byte_cur  = colour ? CH_M : CH_H;
        last_cur  = 1'b1;
        job_ready = adv;
      end
      default:    byte_cur = CH_SEMI;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_ESC;
      hdr   <= '0;
      lane  <= '0;
      dig   <= '0;
    end else begin
      state <= state_next;
      hdr   <= hdr_next;
      lane  <= lane_next;
      dig   <= dig_next;
    end
  end

  // Output register: refilled whenever a command is queued and the register is empty or its beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (adv) begin
      ov <= 1'b1;
    end else if (seq.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ob <= byte_cur;
      ol <= last_cur;
    end
  end

  assign seq.valid    = ov;
  assign seq.out_byte = ob;
  assign seq.last     = ol;

endmodule

`default_nettype wire

FILE: hdl/terminal_control_sequence_encoder_top.sv
// Top level of the terminal control sequence encoder.
//
// Channels: cmd takes one command per beat (cursor move or 24-bit colour);
// seq gives the ASCII bytes of the matching control sequence, one byte per
// beat, with last set on the final byte. A cursor move gives 4 to 14 bytes,
// a colour command always 19.
// The first byte of a sequence is offered on seq once its command has passed
// the bit-serial BCD conversion in the front end, the queue and the output
// register of the back end; most of the delay is the conversion.
// The front end takes a new command only once the current one is converted
// and handed on, while the back end emits one byte per cycle whenever a
// command is queued and the receiver is ready, so a stream of colour commands
// is limited by byte emission and one of short cursor moves by the conversion.
// A two-entry queue between the two halves lets conversion of the next
// command overlap emission of the current one.
// Reset empties the queue and the output register and returns both halves to
// their start state. When the receiver stalls, the output byte holds, the
// queue fills and then cmd.ready drops.
`default_nettype none

module terminal_control_sequence_encoder_top #(
  parameter int COORD_BITS = tcse_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  tcse_cmd_if.sink    cmd,
  tcse_byte_if.source seq
);
  import tcse_pkg::*;

  localparam int CW     = (COORD_BITS < CMD_COORD_W) ? COORD_BITS : CMD_COORD_W;
  localparam int CONV_W = (CW < CHAN_W) ? CHAN_W : CW;
  localparam int NDIG   = (CONV_W * 30103) / 100000 + 1;
  localparam int CNT_W  = $clog2(NDIG + 1);
  localparam int DIGS_W = LANES * NDIG * 4;
  localparam int JOB_W  = $bits(cmd_ctrl_t) + DIGS_W + 2 * CNT_W;

  logic                  fr_valid;
  logic                  fr_ready;
  cmd_ctrl_t             fr_ctrl;
  logic [DIGS_W-1:0]     fr_digits;
  logic [CNT_W-1:0]      fr_cnt0;
  logic [CNT_W-1:0]      fr_cnt1;
  logic [JOB_W-1:0]      q_in;
  logic [JOB_W-1:0]      q_out;
  logic                  bk_valid;
  logic                  bk_ready;
  cmd_ctrl_t             bk_ctrl;
  logic [DIGS_W-1:0]     bk_digits;
  logic [CNT_W-1:0]      bk_cnt0;
  logic [CNT_W-1:0]      bk_cnt1;

  // Command intake and decimal conversion.
  tcse_front #(
    .COORD_BITS (COORD_BITS),
    .CONV_W     (CONV_W),
    .NDIG       (NDIG),
    .CNT_W      (CNT_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .job_valid  (fr_valid),
    .job_ready  (fr_ready),
    .job_ctrl   (fr_ctrl),
    .job_digits (fr_digits),
    .job_cnt0   (fr_cnt0),
    .job_cnt1   (fr_cnt1)
  );

  assign q_in = {fr_ctrl, fr_digits, fr_cnt1, fr_cnt0};

  // Queue of converted commands.
  tcse_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_data   (q_in),
    .out_valid (bk_valid),
    .out_ready (bk_ready),
    .out_data  (q_out)
  );

  assign {bk_ctrl, bk_digits, bk_cnt1, bk_cnt0} = q_out;

  // Byte emission.
  tcse_back #(
    .NDIG  (NDIG),
    .CNT_W (CNT_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (bk_valid),
    .job_ready  (bk_ready),
    .job_ctrl   (bk_ctrl),
    .job_digits (bk_digits),
    .job_cnt0   (bk_cnt0),
    .job_cnt1   (bk_cnt1),
    .seq        (seq)
  );

endmodule

`default_nettype wire

FILE: hdl/tcse_checker.sv
// Port-level checks on the byte stream of the encoder, bound to the top level.
`default_nettype none

module tcse_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tcse_pkg::BYTE_W-1:0] out_byte,
  input logic                        out_last
);
  import tcse_pkg::*;

  logic       sop;
  logic       prev_esc;
  logic [4:0] beats;
  logic       beat;

  assign beat = out_valid && out_ready;

  // Track the position within the current sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      sop      <= 1'b1;
      prev_esc <= 1'b0;
      beats    <= '0;
    end else if (beat) begin
      sop      <= out_last;
      prev_esc <= (out_byte == CH_ESC) && !out_last;
      beats    <= out_last ? 5'd0 : beats + 5'd1;
    end
  end

  // A stalled byte holds its value.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output beat changed while stalled");

  // Every sequence opens with ESC.
  a_start_esc: assert property (@(posedge clk) disable iff (rst)
    out_valid && sop |-> out_byte == CH_ESC)
    else $error("sequence does not start with ESC");

  // ESC is followed by the bracket.
  a_bracket: assert property (@(posedge clk) disable iff (rst)
    out_valid && prev_esc |-> out_byte == CH_LBRACK)
    else $error("ESC not followed by bracket");

  // The final byte is the sequence terminator.
  a_terminator: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> (out_byte == CH_H || out_byte == CH_M))
    else $error("last byte is not a terminator");

  // No sequence is longer than the maximum.
  a_length: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> beats < 5'(SEQ_MAX))
    else $error("sequence too long");

endmodule

bind terminal_control_sequence_encoder_top tcse_checker u_tcse_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (seq.valid),
  .out_ready (seq.ready),
  .out_byte  (seq.out_byte),
  .out_last  (seq.last)
);

`default_nettype wire
